// File: rtl/tghq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tghq_pkg
// Shared types and constants for the triangle grid height query block.
// ----------------------------------------------------------------------------
package tghq_pkg;

   localparam int MAX_CELLS_DEFAULT = 4096;

   // Divider working width: remainder and divisor magnitude.
   localparam int DIV_W = 52;
   // Quotient bits produced per division.
   localparam int QUO_W = 32;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_OUT_BOUNDS = 2'd1;
   localparam logic [1:0] STATUS_DEGENERATE = 2'd2;

   localparam logic [1:0] REG_GRID_ROWS = 2'd0;
   localparam logic [1:0] REG_GRID_COLS = 2'd1;
   localparam logic [1:0] REG_CELL_SIZE = 2'd2;

   localparam logic [6:0]  GRID_ROWS_RESET = 7'd65;
   localparam logic [6:0]  GRID_COLS_RESET = 7'd65;
   localparam logic [15:0] CELL_SIZE_RESET = 16'd256;

   typedef struct packed {
      logic               op;
      logic [11:0]        cell_number;
      logic [1:0]         corner;
      logic signed [23:0] corner_x;
      logic signed [23:0] corner_y;
      logic signed [23:0] corner_z;
      logic signed [23:0] point_x;
      logic signed [23:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [23:0] height;
      logic [1:0]         status;
      logic               triangle_used;
   } rsp_type;

endpackage

// File: rtl/tghq_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tghq_div
// Restoring divider: one quotient bit per cycle, 32 steps per division.
// ----------------------------------------------------------------------------
module tghq_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [tghq_pkg::DIV_W-1:0]  rem_init,
   input  wire logic [tghq_pkg::QUO_W-1:0]  dividend_lo,
   input  wire logic [tghq_pkg::DIV_W-1:0]  divisor,
   output logic                             done,
   output logic [tghq_pkg::QUO_W-1:0]       quotient
);
   import tghq_pkg::*;

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [4:0]           cnt_ff, cnt_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [QUO_W-1:0]     bits_ff, bits_in;
   logic [QUO_W-1:0]     quo_ff, quo_in;
   logic [DIV_W-1:0]     div_ff, div_in;
   logic [DIV_W:0]       trial;
   logic [DIV_W:0]       diff;

   assign trial = {rem_ff, bits_ff[QUO_W-1]};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      bits_in = bits_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         run_in  = 1'b1;
         cnt_in  = '0;
         rem_in  = rem_init;
         bits_in = dividend_lo;
         div_in  = divisor;
      end else if (run_ff) begin
         cnt_in  = cnt_ff + 5'd1;
         bits_in = {bits_ff[QUO_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = diff[DIV_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
         if (cnt_ff == 5'd31) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      bits_ff <= bits_in;
      quo_ff  <= quo_in;
      div_ff  <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// File: rtl/triangle_grid_height_query.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_grid_height_query
// Terrain height lookup over a grid of cells split into two triangles each.
// ----------------------------------------------------------------------------
// A load item writes one cell corner into the corner memories in the cycle it
// is accepted and gives no result. A query item gives exactly one result, shown
// on rsp_data for a single cycle with rsp_valid high; the receiver cannot stall
// it, so it must take the item in that cycle. The block works on one item at a
// time and holds busy high while a query is in progress; busy is already low
// when the result is shown. A query whose point or configuration is out of
// range is answered at once from idle, in the cycle after it is accepted,
// without raising busy. Otherwise the cell is found with two 32-step divisions
// in the shared bit-serial divider, the cell index is checked, the four corners
// are read from memory, and each triangle that is solved passes through the
// shared multiplier, a setup step, two weight divisions and a check step.
// The second triangle is solved only when the point lies outside the first. A
// zero denominator ends a query with a degenerate status; otherwise the corner
// heights are blended by the weights at the end.
// Corners are held in two single-port-write memories of MAX_CELLS*4 entries
// with a registered read; an entry that was never loaded reads back unknown
// data.
// ----------------------------------------------------------------------------
module triangle_grid_height_query #(
   parameter int MAX_CELLS = tghq_pkg::MAX_CELLS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire tghq_pkg::req_type req_data,
   output logic                   busy,
   output logic                   rsp_valid,
   output tghq_pkg::rsp_type      rsp_data,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [15:0]       csr_wdata
);
   import tghq_pkg::*;

   localparam int CELL_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam int ADDR_W = CELL_W + 2;
   localparam int DEPTH  = MAX_CELLS * 4;

   typedef enum logic [11:0] {
      ST_IDLE  = 12'b0000_0000_0001,
      ST_DIVX  = 12'b0000_0000_0010,
      ST_DIVZ  = 12'b0000_0000_0100,
      ST_CELL  = 12'b0000_0000_1000,
      ST_READ  = 12'b0000_0001_0000,
      ST_MUL   = 12'b0000_0010_0000,
      ST_SOLVE = 12'b0000_0100_0000,
      ST_W1    = 12'b0000_1000_0000,
      ST_W2    = 12'b0001_0000_0000,
      ST_CHK   = 12'b0010_0000_0000,
      ST_BLEND = 12'b0100_0000_0000,
      ST_FIN   = 12'b1000_0000_0000
   } state_type;

   // Corner memories: plane holds x in the low half and z in the high half.
   logic [47:0] mem_plane  [DEPTH];
   logic [23:0] mem_height [DEPTH];
   logic [47:0] rd_plane_ff;
   logic [23:0] rd_height_ff;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [31:0]       cn_ext;
   logic [31:0]       k_ext;

   state_type state_ff, state_in;
   logic [6:0]  rows_ff, cols_ff;
   logic [15:0] csize_ff;
   logic signed [23:0] px_ff, px_in, pz_ff, pz_in;
   logic              cx_oob_ff, cx_oob_in;
   logic [6:0]        cx_ff, cx_in;
   logic [13:0]       k_ff, k_in;
   logic [2:0]        cnt_ff, cnt_in;
   logic              tri_ff, tri_in;
   logic signed [23:0] vx_ff [4];
   logic signed [23:0] vz_ff [4];
   logic signed [23:0] vy_ff [4];
   logic              cap_en;
   logic [1:0]        cap_idx;
   logic signed [50:0] den_ff, den_in, n1_ff, n1_in, n2_ff, n2_in;
   logic signed [59:0] prod_ff, prod_in;
   logic signed [33:0] w0_ff, w0_in, w1_ff, w1_in;
   logic signed [34:0] w2;
   logic signed [61:0] acc_ff, acc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   // Divider hookup.
   logic              div_start;
   logic [DIV_W-1:0]  div_rem;
   logic [QUO_W-1:0]  div_lo;
   logic [DIV_W-1:0]  div_den;
   logic              div_done;
   logic [QUO_W-1:0]  div_q;

   // Triangle vertex selection: first is TL/BL/TR, second TR/BR/BL.
   logic [1:0] ia, ib, ic;
   logic signed [24:0] d1, d2, e1, e2, f1, f2, g1;
   logic signed [34:0] mul_a;
   logic signed [24:0] mul_b;
   logic signed [50:0] p51;

   // Weight magnitudes and saturation.
   logic [50:0] mag_den, mag_n1, mag_n2;
   logic        sat1, sat2, neg1, neg2;
   logic [32:0] m1, m2;

   logic        prelim_oob;
   logic [6:0]  cols_m1, rows_m1;
   logic [61:0] acc_mag;
   logic [45:0] hmag;
   logic signed [23:0] hsat;

   assign cn_ext  = 32'(req_data.cell_number);
   assign k_ext   = 32'(k_ff);
   assign wr_en   = start && !busy && (req_data.op == OP_LOAD)
                    && (cn_ext < 32'(MAX_CELLS));
   assign wr_addr = {cn_ext[CELL_W-1:0], req_data.corner};
   assign rd_addr = {k_ext[CELL_W-1:0], cnt_ff[1:0]};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_plane[wr_addr]  <= {req_data.corner_z, req_data.corner_x};
         mem_height[wr_addr] <= req_data.corner_y;
      end
      rd_plane_ff  <= mem_plane[rd_addr];
      rd_height_ff <= mem_height[rd_addr];
   end

   tghq_div u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .rem_init    (div_rem),
      .dividend_lo (div_lo),
      .divisor     (div_den),
      .done        (div_done),
      .quotient    (div_q)
   );

   assign ia = tri_ff ? 2'd2 : 2'd0;
   assign ib = tri_ff ? 2'd3 : 2'd1;
   assign ic = tri_ff ? 2'd1 : 2'd2;

   assign d1 = 25'(vz_ff[ib]) - 25'(vz_ff[ic]);
   assign e1 = 25'(vx_ff[ia]) - 25'(vx_ff[ic]);
   assign d2 = 25'(vx_ff[ic]) - 25'(vx_ff[ib]);
   assign e2 = 25'(vz_ff[ia]) - 25'(vz_ff[ic]);
   assign f1 = 25'(px_ff) - 25'(vx_ff[ic]);
   assign f2 = 25'(pz_ff) - 25'(vz_ff[ic]);
   assign g1 = 25'(vz_ff[ic]) - 25'(vz_ff[ia]);

   assign w2 = 35'sd65536 - 35'(w0_ff) - 35'(w1_ff);

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_MUL) begin
         case (cnt_ff)
            3'd0: begin mul_a = 35'(d1); mul_b = e1; end
            3'd1: begin mul_a = 35'(d2); mul_b = e2; end
            3'd2: begin mul_a = 35'(d1); mul_b = f1; end
            3'd3: begin mul_a = 35'(d2); mul_b = f2; end
            3'd4: begin mul_a = 35'(g1); mul_b = f1; end
            3'd5: begin mul_a = 35'(e1); mul_b = f2; end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end else begin
         case (cnt_ff)
            3'd0: begin mul_a = 35'(w0_ff); mul_b = 25'(vy_ff[ia]); end
            3'd1: begin mul_a = 35'(w1_ff); mul_b = 25'(vy_ff[ib]); end
            3'd2: begin mul_a = w2;         mul_b = 25'(vy_ff[ic]); end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end
   end

   assign p51 = prod_ff[50:0];

   assign mag_den = den_ff[50] ? 51'(-den_ff) : 51'(den_ff);
   assign mag_n1  = n1_ff[50] ? 51'(-n1_ff) : 51'(n1_ff);
   assign mag_n2  = n2_ff[50] ? 51'(-n2_ff) : 51'(n2_ff);
   assign sat1    = (mag_n1 >> 16) >= mag_den;
   assign sat2    = (mag_n2 >> 16) >= mag_den;
   assign neg1    = n1_ff[50] != den_ff[50];
   assign neg2    = n2_ff[50] != den_ff[50];
   assign m1      = sat1 ? 33'h1_0000_0000 : {1'b0, div_q};
   assign m2      = sat2 ? 33'h1_0000_0000 : {1'b0, div_q};

   assign prelim_oob = (rows_ff < 7'd2) || (cols_ff < 7'd2) || (csize_ff == 16'd0)
                       || req_data.point_x[23] || req_data.point_z[23];
   assign cols_m1 = cols_ff - 7'd1;
   assign rows_m1 = rows_ff - 7'd1;

   // Final scaling and saturation of the blended sum.
   assign acc_mag = acc_ff[61] ? 62'(-acc_ff) : 62'(acc_ff);
   assign hmag    = acc_mag[61:16];
   always_comb begin
      if (acc_ff[61]) begin
         if (hmag > 46'h80_0000) hsat = 24'sh80_0000;
         else                    hsat = 24'(-$signed({1'b0, hmag[23:0]}));
      end else begin
         if (hmag > 46'h7F_FFFF) hsat = 24'sh7F_FFFF;
         else                    hsat = hmag[23:0];
      end
   end

   assign cap_en  = (state_ff == ST_READ) && (cnt_ff != 3'd0);
   assign cap_idx = 2'(cnt_ff - 3'd1);

   always_comb begin
      state_in     = state_ff;
      px_in        = px_ff;
      pz_in        = pz_ff;
      cx_oob_in    = cx_oob_ff;
      cx_in        = cx_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      tri_in       = tri_ff;
      den_in       = den_ff;
      n1_in        = n1_ff;
      n2_in        = n2_ff;
      prod_in      = prod_ff;
      w0_in        = w0_ff;
      w1_in        = w1_ff;
      acc_in       = acc_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      div_start    = 1'b0;
      div_rem      = '0;
      div_lo       = '0;
      div_den      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start && (req_data.op == OP_QUERY)) begin
               px_in  = req_data.point_x;
               pz_in  = req_data.point_z;
               tri_in = 1'b0;
               if (prelim_oob) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{height: '0, status: STATUS_OUT_BOUNDS,
                                   triangle_used: 1'b0};
               end else begin
                  div_start = 1'b1;
                  div_lo    = QUO_W'(req_data.point_x[22:0]);
                  div_den   = DIV_W'(csize_ff);
                  state_in  = ST_DIVX;
               end
            end
         end
         ST_DIVX: begin
            if (div_done) begin
               cx_oob_in = div_q >= QUO_W'(cols_m1);
               cx_in     = div_q[6:0];
               div_start = 1'b1;
               div_lo    = QUO_W'(pz_ff[22:0]);
               div_den   = DIV_W'(csize_ff);
               state_in  = ST_DIVZ;
            end
         end
         ST_DIVZ: begin
            if (div_done) begin
               k_in = 14'(div_q[6:0]) * 14'(cols_m1) + 14'(cx_ff);
               if (cx_oob_ff || (div_q >= QUO_W'(rows_m1))) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{height: '0, status: STATUS_OUT_BOUNDS,
                                   triangle_used: 1'b0};
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_CELL;
               end
            end
         end
         ST_CELL: begin
            cnt_in = '0;
            if (32'(k_ff) >= 32'(MAX_CELLS)) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{height: '0, status: STATUS_OUT_BOUNDS,
                                triangle_used: 1'b0};
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd4) begin
               cnt_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cnt_in  = cnt_ff + 3'd1;
            prod_in = mul_a * mul_b;
            case (cnt_ff)
               3'd1: den_in = p51;
               3'd2: den_in = den_ff + p51;
               3'd3: n1_in  = p51;
               3'd4: n1_in  = n1_ff + p51;
               3'd5: n2_in  = p51;
               3'd6: n2_in  = n2_ff + p51;
               default: ;
            endcase
            if (cnt_ff == 3'd6) begin
               state_in = ST_SOLVE;
            end
         end
         ST_SOLVE: begin
            if (den_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{height: '0, status: STATUS_DEGENERATE,
                                triangle_used: tri_ff};
               state_in     = ST_IDLE;
            end else begin
               div_start = 1'b1;
               div_rem   = DIV_W'(mag_n1 >> 16);
               div_lo    = {mag_n1[15:0], 16'd0};
               div_den   = DIV_W'(mag_den);
               state_in  = ST_W1;
            end
         end
         ST_W1: begin
            if (div_done) begin
               w0_in     = neg1 ? -$signed({1'b0, m1}) : $signed({1'b0, m1});
               div_start = 1'b1;
               div_rem   = DIV_W'(mag_n2 >> 16);
               div_lo    = {mag_n2[15:0], 16'd0};
               div_den   = DIV_W'(mag_den);
               state_in  = ST_W2;
            end
         end
         ST_W2: begin
            if (div_done) begin
               w1_in    = neg2 ? -$signed({1'b0, m2}) : $signed({1'b0, m2});
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            cnt_in = '0;
            if (!tri_ff && (w0_ff[33] || w1_ff[33] || w2[34])) begin
               // The point lies outside the first triangle: solve the second.
               tri_in   = 1'b1;
               state_in = ST_MUL;
            end else begin
               state_in = ST_BLEND;
            end
         end
         ST_BLEND: begin
            cnt_in  = cnt_ff + 3'd1;
            prod_in = mul_a * mul_b;
            case (cnt_ff)
               3'd1: acc_in = 62'(prod_ff);
               3'd2: acc_in = acc_ff + 62'(prod_ff);
               3'd3: acc_in = acc_ff + 62'(prod_ff);
               default: ;
            endcase
            if (cnt_ff == 3'd3) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '{height: hsat, status: STATUS_OK, triangle_used: tri_ff};
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rows_ff      <= GRID_ROWS_RESET;
         cols_ff      <= GRID_COLS_RESET;
         csize_ff     <= CELL_SIZE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               REG_GRID_ROWS: rows_ff  <= csr_wdata[6:0];
               REG_GRID_COLS: cols_ff  <= csr_wdata[6:0];
               REG_CELL_SIZE: csize_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      px_ff     <= px_in;
      pz_ff     <= pz_in;
      cx_oob_ff <= cx_oob_in;
      cx_ff     <= cx_in;
      k_ff      <= k_in;
      cnt_ff    <= cnt_in;
      tri_ff    <= tri_in;
      den_ff    <= den_in;
      n1_ff     <= n1_in;
      n2_ff     <= n2_in;
      prod_ff   <= prod_in;
      w0_ff     <= w0_in;
      w1_ff     <= w1_in;
      acc_ff    <= acc_in;
      rsp_ff    <= rsp_in;
      if (cap_en) begin
         vx_ff[cap_idx] <= rd_plane_ff[23:0];
         vz_ff[cap_idx] <= rd_plane_ff[47:24];
         vy_ff[cap_idx] <= rd_height_ff;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire
